### hw/rtl/pdht_pkg.sv
`default_nettype none
package pdht_pkg;

  localparam int MAX_BUCKETS = 8192;
  localparam int MAX_NODES   = 1024;
  localparam int COORD_W     = 16;
  localparam int CFG_W       = 14;
  localparam int ID_W        = 11;

  localparam int BKT_AW = $clog2(MAX_BUCKETS);
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int REM_W  = $clog2(MAX_BUCKETS + 1);

  // Cantor pairing: s = x + y, product s * (s + 1), value y + product / 2
  localparam int S_W       = COORD_W + 1;
  localparam int PROD_W    = 2 * S_W + 1;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (PROD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DVD_W     = DIV_STEPS * DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] BUCKET_RESET = CFG_W'(5000);

  typedef struct packed {
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
  } pdht_in_t;

  typedef struct packed {
    logic [ID_W-1:0] node_id;
    logic            created;
    logic            table_full;
  } pdht_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ID_W-1:0]    next;
  } pdht_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_LOOK,
    ST_ENT_WAIT,
    ST_INSERT,
    ST_RESP
  } pdht_state_t;

endpackage
`default_nettype wire

### hw/rtl/point_dedup_hash_table_top.sv
// Channel   Direction  Payload      Transaction
// in_       input      pdht_in_t    one point (coord_x, coord_y) to look up
// out_      output     pdht_out_t   node_id, created, table_full for that point
// cfg_      input      14 bits      new bucket count, taken in any cycle
//
// One point at a time: after accept a lookup runs ST_MUL, ST_ADD, ST_DIV,
// ST_HEAD_RD and ST_HEAD_WAIT, then ST_LOOK and ST_ENT_WAIT for each chain
// entry visited, the matching one included on a hit; a miss ends in ST_INSERT.
// The modulo unit retires 4 dividend bits a cycle and every chain step is a
// registered read of the entry RAM. After reset a clearing pass writes all
// 8192 bucket heads, one a cycle; in_ready stays low until the pass is done.
// A new point is accepted while the previous result still waits in the
// output register.
`default_nettype none
module point_dedup_hash_table_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire pdht_pkg::pdht_in_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output pdht_pkg::pdht_out_t            out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [pdht_pkg::CFG_W-1:0] cfg_data
);

  import pdht_pkg::*;

  pdht_state_t         state_r, state_nxt;
  logic [BKT_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [S_W-1:0]      s_r, s_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [ID_W-1:0]     cur_id_r, cur_id_nxt;
  logic [ID_W-1:0]     head_r, head_nxt;
  logic [ID_W-1:0]     node_cnt_r, node_cnt_nxt;
  pdht_out_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  pdht_out_t           out_data_r, out_data_nxt;
  logic [CFG_W-1:0]    cfg_r, cfg_nxt;

  logic [REM_W-1:0]    eff_buckets;
  logic [REM_W-1:0]    rem_step;

  logic                head_we;
  logic [BKT_AW-1:0]   head_waddr;
  logic [ID_W-1:0]     head_wdata;
  logic [ID_W-1:0]     head_rdata;
  logic                ent_we;
  logic [NODE_AW-1:0]  ent_waddr;
  pdht_entry_t         ent_wdata;
  logic [NODE_AW-1:0]  ent_raddr;
  logic [$bits(pdht_entry_t)-1:0] ent_rdata_raw;
  pdht_entry_t         ent_rdata;
  logic [BKT_AW-1:0]   bucket;
  logic [ID_W-1:0]     id_dec;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign bucket    = rem_r[BKT_AW-1:0];
  assign ent_rdata = pdht_entry_t'(ent_rdata_raw);
  assign id_dec    = cur_id_r - ID_W'(1);

  // Zero acts as one bucket, anything above the table size saturates.
  always_comb begin
    if (cfg_r == '0) begin
      eff_buckets = REM_W'(1);
    end else if (REM_W'(cfg_r) > REM_W'(MAX_BUCKETS)) begin
      eff_buckets = REM_W'(MAX_BUCKETS);
    end else begin
      eff_buckets = REM_W'(cfg_r);
    end
  end

  // Restoring remainder, DIV_BITS dividend bits per cycle, MSB first.
  always_comb begin
    logic [REM_W:0] t;
    rem_step = rem_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {rem_step, dvd_r[DVD_W-1-k]};
      if (t >= {1'b0, eff_buckets}) begin
        t = t - {1'b0, eff_buckets};
      end
      rem_step = t[REM_W-1:0];
    end
  end

  pdht_ram #(.WIDTH(ID_W), .DEPTH(MAX_BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  pdht_ram #(.WIDTH($bits(pdht_entry_t)), .DEPTH(MAX_NODES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata_raw)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    s_nxt         = s_r;
    prod_nxt      = prod_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    cur_id_nxt    = cur_id_r;
    head_nxt      = head_r;
    node_cnt_nxt  = node_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cfg_nxt       = cfg_valid ? cfg_data : cfg_r;
    in_ready      = 1'b0;
    head_we       = 1'b0;
    head_waddr    = bucket;
    head_wdata    = node_cnt_r + ID_W'(1);
    ent_we        = 1'b0;
    ent_waddr     = node_cnt_r[NODE_AW-1:0];
    ent_wdata     = '{x: x_r, y: y_r, next: head_r};
    ent_raddr     = id_dec[NODE_AW-1:0];

    // Drop the result register once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // Write the empty-chain marker into every bucket head.
        head_we    = 1'b1;
        head_waddr = clr_cnt_r;
        head_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + BKT_AW'(1);
        if (clr_cnt_r == BKT_AW'(MAX_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x_nxt     = in_data.coord_x;
          y_nxt     = in_data.coord_y;
          s_nxt     = S_W'(in_data.coord_x) + S_W'(in_data.coord_y);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(s_r) * PROD_W'(s_r + S_W'(1));
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        dvd_nxt   = DVD_W'(prod_r[PROD_W-1:1]) + DVD_W'(y_r);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = dvd_r << DIV_BITS;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_HEAD_RD;
        end
      end
      ST_HEAD_RD: begin
        // Bucket address is on the read port; data lands next cycle.
        state_nxt = ST_HEAD_WAIT;
      end
      ST_HEAD_WAIT: begin
        head_nxt   = head_rdata;
        cur_id_nxt = head_rdata;
        state_nxt  = ST_LOOK;
      end
      ST_LOOK: begin
        if (cur_id_r == '0) begin
          state_nxt = ST_INSERT;
        end else begin
          state_nxt = ST_ENT_WAIT;
        end
      end
      ST_ENT_WAIT: begin
        if (ent_rdata.x == x_r && ent_rdata.y == y_r) begin
          res_nxt   = '{node_id: cur_id_r, created: 1'b0, table_full: 1'b0};
          state_nxt = ST_RESP;
        end else begin
          cur_id_nxt = ent_rdata.next;
          state_nxt  = ST_LOOK;
        end
      end
      ST_INSERT: begin
        if (node_cnt_r == ID_W'(MAX_NODES)) begin
          res_nxt = '{node_id: '0, created: 1'b0, table_full: 1'b1};
        end else begin
          // Push the new entry at the chain head.
          ent_we       = 1'b1;
          head_we      = 1'b1;
          node_cnt_nxt = node_cnt_r + ID_W'(1);
          res_nxt = '{node_id: node_cnt_r + ID_W'(1), created: 1'b1, table_full: 1'b0};
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      node_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= BUCKET_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      node_cnt_r  <= node_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    s_r        <= s_nxt;
    prod_r     <= prod_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    cur_id_r   <= cur_id_nxt;
    head_r     <= head_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_cnt_r <= ID_W'(MAX_NODES))
    else $error("node count above pool size");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second point accepted while one is in flight");

  a_result_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> !out_data.created && out_data.node_id == '0)
    else $error("full result carries an id or a create flag");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INSERT && !res_nxt.table_full |=> node_cnt_r == $past(node_cnt_r) + ID_W'(1))
    else $error("insert did not advance node count");

endmodule
`default_nettype wire

### hw/rtl/pdht_ram.sv
`default_nettype none
module pdht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pdht_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pdht_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pdht_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // Shadow copy of the hash table: chain heads, entry pool, id counter and
  // the bucket count register.
  logic [ID_W-1:0]    head_tbl [MAX_BUCKETS];
  logic [COORD_W-1:0] pool_x [MAX_NODES];
  logic [COORD_W-1:0] pool_y [MAX_NODES];
  logic [ID_W-1:0]    pool_next [MAX_NODES];
  int unsigned        ids_given = 0;
  logic [CFG_W-1:0]   bucket_reg = BUCKET_RESET;

  pdht_in_t  point_q[$];     // points waiting to be offered
  pdht_out_t lookup_q[$];    // predicted lookup answers, oldest first
  pdht_in_t  seen_pts[$];    // points already sent, reused to force hits

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          calm = 1'b0;          // no idling in the last stretch
  bit          stall_req = 1'b0;     // ask the receiver for one long hold-off
  bit          stall_done = 1'b0;

  point_dedup_hash_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hash the point, walk its chain, insert on a miss. Returns the answer the
  // block must give for this point.
  function automatic pdht_out_t dedup_point(pdht_in_t p);
    longint unsigned s, cantor, nb;
    int unsigned     bkt, id, steps;
    pdht_out_t       r;
    nb = (bucket_reg == 0) ? 1 : (bucket_reg > MAX_BUCKETS) ? MAX_BUCKETS : bucket_reg;
    s = longint'(p.coord_x) + longint'(p.coord_y);
    cantor = longint'(p.coord_y) + (s * (s + 1)) / 2;
    bkt = int'(cantor % nb);
    id = head_tbl[bkt];
    steps = 0;
    r = '0;
    while (id != 0 && id <= MAX_NODES && steps < MAX_NODES) begin
      if (pool_x[id-1] == p.coord_x && pool_y[id-1] == p.coord_y) begin
        r.node_id = ID_W'(id);
        return r;
      end
      id = pool_next[id-1];
      steps++;
    end
    if (ids_given >= MAX_NODES) begin
      r.table_full = 1'b1;
      return r;
    end
    pool_x[ids_given] = p.coord_x;
    pool_y[ids_given] = p.coord_y;
    pool_next[ids_given] = head_tbl[bkt];
    ids_given++;
    head_tbl[bkt] = ID_W'(ids_given);
    r.node_id = ID_W'(ids_given);
    r.created = 1'b1;
    return r;
  endfunction

  // Driver: predict on each accepted transaction, then offer the next point
  // or idle for a random burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        lookup_q.push_back(dedup_point(in_data));
        void'(point_q.pop_front());
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= point_q[0];
        if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction and
  // pace out_ready; one long hold-off fills the block and stalls its input.
  always @(posedge clk) begin
    pdht_out_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          $error("unexpected result node_id=%0d", out_data.node_id);
          errors++;
        end else begin
          exp_r = lookup_q.pop_front();
          if (out_data.node_id !== exp_r.node_id) begin
            $error("node_id expected %0d actual %0d", exp_r.node_id, out_data.node_id);
            errors++;
          end
          if (out_data.created !== exp_r.created) begin
            $error("created expected %0b actual %0b", exp_r.created, out_data.created);
            errors++;
          end
          if (out_data.table_full !== exp_r.table_full) begin
            $error("table_full expected %0b actual %0b", exp_r.table_full,
                   out_data.table_full);
            errors++;
          end
        end
      end
      if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        out_gap = 400;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 12);
      end
    end
  end

  // Cap the run; worst case is a long chain walk on every point.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 20_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_buckets(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bucket_reg = v;
  endtask

  task automatic add_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    pdht_in_t p;
    p.coord_x = x;
    p.coord_y = y;
    point_q.push_back(p);
    seen_pts.push_back(p);
  endtask

  // Hold until every point went in and every answer came back.
  task automatic drain();
    do @(posedge clk); while (point_q.size() > 0 || in_valid || lookup_q.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  // Mostly repeats and fresh random points, with some corner coordinates.
  task automatic add_random(input int unsigned n);
    int unsigned k;
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k < 4 && seen_pts.size() > 0)
        point_q.push_back(seen_pts[$urandom_range(0, seen_pts.size() - 1)]);
      else if (k == 4)
        add_point($urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 7)),
                  $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 7)));
      else
        add_point(16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    foreach (head_tbl[i]) head_tbl[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed at the reset modulus: coordinate extremes and repeat hits.
    write_buckets(CFG_W'(5000));
    add_point(16'h0000, 16'h0000);
    add_point(16'h0000, 16'h0000);
    add_point(16'hFFFF, 16'hFFFF);
    add_point(16'hFFFF, 16'h0000);
    add_point(16'h0000, 16'hFFFF);
    add_point(16'h0001, 16'h0000);
    add_point(16'h0000, 16'h0001);
    add_point(16'hFFFF, 16'hFFFF);
    add_point(16'hAAAA, 16'h5555);
    add_point(16'h5555, 16'hAAAA);
    drain();

    // Zero bucket count acts as one bucket; earlier points may re-insert.
    write_buckets('0);
    add_point(16'hFFFF, 16'hFFFF);
    add_point(16'h0001, 16'h0000);
    add_random(20);
    drain();

    // Above the table size: saturate. Park the receiver once here.
    write_buckets(CFG_W'(16383));
    stall_req = 1'b1;
    add_random(300);
    drain();

    write_buckets(CFG_W'(1));
    add_random(20);
    drain();

    write_buckets(CFG_W'(MAX_BUCKETS));
    add_random(300);
    drain();

    write_buckets(CFG_W'(8193));
    add_random(60);
    drain();

    write_buckets(CFG_W'(7));
    add_random(60);
    drain();

    write_buckets(CFG_W'($urandom_range(2, MAX_BUCKETS)));
    add_random(450);
    drain();

    // Last stretch: pool runs full here, no idling on either side.
    write_buckets(CFG_W'($urandom_range(2, MAX_BUCKETS)));
    calm = 1'b1;
    add_random(630);
    drain();
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/pdht_pkg.sv
hw/rtl/pdht_ram.sv
hw/rtl/point_dedup_hash_table_top.sv
sim/testbench.sv
